// ===== rtl/core/format_spec_parser_macros.svh =====
// Assertion macros for the format specifier parser.
// Needs clk and rst_n in the scope where the macros are used.
`ifndef FORMAT_SPEC_PARSER_MACROS_SVH
`define FORMAT_SPEC_PARSER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FSP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FSP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/fsp_pkg.sv =====
// Types, character codes and result codes of the format specifier parser.
// Has no dependencies; imported by format_spec_parser and format_spec_parser_test.
package fsp_pkg;

    // Accumulator width and saturation limit of the width and precision runs.
    localparam int NUMBER_BITS = 16;
    localparam int ACC_W       = 16;
    localparam logic [ACC_W-1:0] SAT_LIMIT = (NUMBER_BITS >= 16) ? {ACC_W{1'b1}} :
        ACC_W'((32'd1 << NUMBER_BITS) - 32'd1);
    localparam int PROD_W = ACC_W + 4;

    // Parse phases.
    typedef enum logic [2:0] {
        PH_FLAG  = 3'd0,
        PH_WIDTH = 3'd1,
        PH_PREC  = 3'd2,
        PH_LEN   = 3'd3,
        PH_LEN_H = 3'd4,
        PH_LEN_L = 3'd5,
        PH_CONV  = 3'd6
    } phase_t;

    // Character codes.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SHARP = 8'h23;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_H     = 8'h68;
    localparam logic [7:0] CH_L     = 8'h6C;
    localparam logic [7:0] CH_J     = 8'h6A;
    localparam logic [7:0] CH_Z     = 8'h7A;
    localparam logic [7:0] CH_S     = 8'h73;
    localparam logic [7:0] CH_P     = 8'h70;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_O     = 8'h6F;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_C     = 8'h63;

    // Flag bit positions.
    localparam int FL_SHARP = 0;
    localparam int FL_PLUS  = 1;
    localparam int FL_SPACE = 2;
    localparam int FL_MINUS = 3;
    localparam int FL_ZERO  = 4;

    // Status codes.
    localparam logic [1:0] ST_COMPLETE  = 2'd0;
    localparam logic [1:0] ST_UNKNOWN   = 2'd1;
    localparam logic [1:0] ST_EARLY_END = 2'd2;

    // Length modifier codes.
    localparam logic [2:0] LEN_NONE = 3'd0;
    localparam logic [2:0] LEN_HH   = 3'd1;
    localparam logic [2:0] LEN_H    = 3'd2;
    localparam logic [2:0] LEN_L    = 3'd3;
    localparam logic [2:0] LEN_LL   = 3'd4;
    localparam logic [2:0] LEN_J    = 3'd5;
    localparam logic [2:0] LEN_Z    = 3'd6;

    // Conversion codes.
    localparam logic [3:0] CONV_S       = 4'd0;
    localparam logic [3:0] CONV_P       = 4'd1;
    localparam logic [3:0] CONV_D       = 4'd2;
    localparam logic [3:0] CONV_O       = 4'd3;
    localparam logic [3:0] CONV_U       = 4'd4;
    localparam logic [3:0] CONV_X       = 4'd5;
    localparam logic [3:0] CONV_C       = 4'd6;
    localparam logic [3:0] CONV_UNKNOWN = 4'd7;
    localparam logic [3:0] CONV_NONE    = 4'd8;

    // True for the characters 0 to 9.
    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // Appends one decimal digit to an accumulator, saturating at the limit.
    function automatic logic [ACC_W-1:0] add_digit(input logic [ACC_W-1:0] acc,
                                                   input logic [7:0] c);
        logic [PROD_W-1:0] v;
        v = PROD_W'(acc) * PROD_W'(10) + PROD_W'(c - CH_ZERO);
        return (v > PROD_W'(SAT_LIMIT)) ? SAT_LIMIT : v[ACC_W-1:0];
    endfunction

    // Maps a conversion character to its code.
    function automatic logic [3:0] conv_code(input logic [7:0] c);
        logic [3:0] r;
        unique case (c)
            CH_S:       r = CONV_S;
            CH_P:       r = CONV_P;
            CH_D, CH_I: r = CONV_D;
            CH_O:       r = CONV_O;
            CH_U:       r = CONV_U;
            CH_X:       r = CONV_X;
            CH_C:       r = CONV_C;
            default:    r = CONV_UNKNOWN;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/core/format_spec_parser.sv =====
// Format specifier parser: flags, width, precision, length and conversion.
// Depends on fsp_pkg and format_spec_parser_macros.svh.
//
//  channel  | signals                               | handshake
//  ---------+---------------------------------------+-----------------------------
//  char     | char_code                             | char_valid / char_ready
//  result   | status, flag_bits, field_width,       | result_valid / result_ready
//           | precision_value, precision_present,   |
//           | length_kind, conversion               |
//
// One word is taken per cycle unless held back as below. A word is registered in
// the input register and parsed against the phase state in a single step, and a
// result is registered in the result register when its final word is parsed. A
// full result register holds back only a word that ends a spec, and the words
// behind it wait in turn; other words keep flowing. Reset clears the phase and
// all parse stores, giving an empty spec in the flag phase.
`include "format_spec_parser_macros.svh"

module format_spec_parser
    import fsp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             char_valid,
    output logic             char_ready,
    input  logic [7:0]       char_code,
    output logic             result_valid,
    input  logic             result_ready,
    output logic [1:0]       status,
    output logic [4:0]       flag_bits,
    output logic [ACC_W-1:0] field_width,
    output logic [ACC_W-1:0] precision_value,
    output logic             precision_present,
    output logic [2:0]       length_kind,
    output logic [3:0]       conversion
);

    // Input register.
    logic             char_valid_reg;
    logic [7:0]       char_reg;

    // Parse state.
    phase_t           phase_reg, phase_next;
    logic [4:0]       flag_reg, flag_next;
    logic [ACC_W-1:0] width_reg, width_next;
    logic [ACC_W-1:0] prec_reg, prec_next;
    logic             pseen_reg, pseen_next;
    logic [2:0]       len_reg, len_next;

    // Result register.
    logic             result_valid_reg;
    logic [1:0]       status_reg;
    logic [4:0]       flag_out_reg;
    logic [ACC_W-1:0] width_out_reg;
    logic [ACC_W-1:0] prec_out_reg;
    logic             pseen_out_reg;
    logic [2:0]       len_out_reg;
    logic [3:0]       conv_out_reg;

    // Step outputs.
    phase_t           ph;
    logic [4:0]       fl;
    logic [ACC_W-1:0] wa;
    logic [ACC_W-1:0] pa;
    logic             ps;
    logic [2:0]       ln;
    logic             done;
    logic             emit;
    logic [1:0]       st;
    logic [3:0]       cv;
    logic             out_free;
    logic             step_fire;

    // Parse step: a word that does not fit the current phase falls into the next.
    always_comb
    begin
        ph   = phase_reg;
        fl   = flag_reg;
        wa   = width_reg;
        pa   = prec_reg;
        ps   = pseen_reg;
        ln   = len_reg;
        done = 1'b0;
        emit = 1'b0;
        st   = ST_COMPLETE;
        cv   = CONV_NONE;

        // End of string: a pending single h or l still counts.
        if (char_reg == CH_NUL)
        begin
            if (ph == PH_LEN_H)
            begin
                ln = LEN_H;
            end
            else if (ph == PH_LEN_L)
            begin
                ln = LEN_L;
            end
            emit = 1'b1;
            st   = ST_EARLY_END;
            done = 1'b1;
        end

        // Flags; plus beats space and minus beats zero.
        if (!done && ph == PH_FLAG)
        begin
            done = 1'b1;
            priority if (char_reg == CH_SHARP)
            begin
                fl[FL_SHARP] = 1'b1;
            end
            else if (char_reg == CH_PLUS)
            begin
                fl[FL_PLUS]  = 1'b1;
                fl[FL_SPACE] = 1'b0;
            end
            else if (char_reg == CH_SPACE)
            begin
                if (!fl[FL_PLUS])
                begin
                    fl[FL_SPACE] = 1'b1;
                end
            end
            else if (char_reg == CH_MINUS)
            begin
                fl[FL_MINUS] = 1'b1;
                fl[FL_ZERO]  = 1'b0;
            end
            else if (char_reg == CH_ZERO)
            begin
                if (!fl[FL_MINUS])
                begin
                    fl[FL_ZERO] = 1'b1;
                end
            end
            else
            begin
                ph   = PH_WIDTH;
                done = 1'b0;
            end
        end

        // Width digits, or the dot that opens the precision.
        if (!done && ph == PH_WIDTH)
        begin
            done = 1'b1;
            priority if (is_digit(char_reg))
            begin
                wa = add_digit(wa, char_reg);
            end
            else if (char_reg == CH_DOT)
            begin
                ps = 1'b1;
                pa = '0;
                ph = PH_PREC;
            end
            else
            begin
                ph   = PH_LEN;
                done = 1'b0;
            end
        end

        // Precision digits.
        if (!done && ph == PH_PREC)
        begin
            if (is_digit(char_reg))
            begin
                pa   = add_digit(pa, char_reg);
                done = 1'b1;
            end
            else
            begin
                ph = PH_LEN;
            end
        end

        // First character of a length modifier.
        if (!done && ph == PH_LEN)
        begin
            done = 1'b1;
            priority if (char_reg == CH_H)
            begin
                ph = PH_LEN_H;
            end
            else if (char_reg == CH_L)
            begin
                ph = PH_LEN_L;
            end
            else if (char_reg == CH_J)
            begin
                ln = LEN_J;
                ph = PH_CONV;
            end
            else if (char_reg == CH_Z)
            begin
                ln = LEN_Z;
                ph = PH_CONV;
            end
            else
            begin
                ph   = PH_CONV;
                done = 1'b0;
            end
        end

        // Second h, or a single h followed by the conversion.
        if (!done && ph == PH_LEN_H)
        begin
            ph = PH_CONV;
            if (char_reg == CH_H)
            begin
                ln   = LEN_HH;
                done = 1'b1;
            end
            else
            begin
                ln = LEN_H;
            end
        end

        // Second l, or a single l followed by the conversion.
        if (!done && ph == PH_LEN_L)
        begin
            ph = PH_CONV;
            if (char_reg == CH_L)
            begin
                ln   = LEN_LL;
                done = 1'b1;
            end
            else
            begin
                ln = LEN_L;
            end
        end

        // Conversion character; the unused phase code lands here as well.
        if (!done)
        begin
            cv   = conv_code(char_reg);
            st   = (cv == CONV_UNKNOWN) ? ST_UNKNOWN : ST_COMPLETE;
            emit = 1'b1;
        end
    end

    // Next state: a finished spec leaves an empty one behind.
    always_comb
    begin
        if (emit)
        begin
            phase_next = PH_FLAG;
            flag_next  = '0;
            width_next = '0;
            prec_next  = '0;
            pseen_next = 1'b0;
            len_next   = LEN_NONE;
        end
        else
        begin
            phase_next = ph;
            flag_next  = fl;
            width_next = wa;
            prec_next  = pa;
            pseen_next = ps;
            len_next   = ln;
        end
    end

    // Handshake: a word that ends a spec needs room in the result register.
    always_comb
    begin
        out_free   = !result_valid_reg || result_ready;
        step_fire  = char_valid_reg && (!emit || out_free);
        char_ready = !char_valid_reg || step_fire;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
            phase_reg        <= PH_FLAG;
            flag_reg         <= '0;
            width_reg        <= '0;
            prec_reg         <= '0;
            pseen_reg        <= 1'b0;
            len_reg          <= LEN_NONE;
        end
        else
        begin
            if (char_ready)
            begin
                char_valid_reg <= char_valid;
            end
            if (step_fire && emit)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
            if (step_fire)
            begin
                phase_reg <= phase_next;
                flag_reg  <= flag_next;
                width_reg <= width_next;
                prec_reg  <= prec_next;
                pseen_reg <= pseen_next;
                len_reg   <= len_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (char_ready && char_valid)
        begin
            char_reg <= char_code;
        end
        if (step_fire && emit)
        begin
            status_reg    <= st;
            flag_out_reg  <= fl;
            width_out_reg <= wa;
            prec_out_reg  <= pa;
            pseen_out_reg <= ps;
            len_out_reg   <= ln;
            conv_out_reg  <= cv;
        end
    end

    // Result ports.
    assign result_valid      = result_valid_reg;
    assign status            = status_reg;
    assign flag_bits         = flag_out_reg;
    assign field_width       = width_out_reg;
    assign precision_value   = prec_out_reg;
    assign precision_present = pseen_out_reg;
    assign length_kind       = len_out_reg;
    assign conversion        = conv_out_reg;

    // Checks on the parse logic.
    `FSP_ASSERT_NOW(a_early_end_no_conv, result_valid && status == ST_EARLY_END, conversion == CONV_NONE, "early end with a conversion code")
    `FSP_ASSERT_NOW(a_no_dot_no_prec, result_valid && !precision_present, precision_value == '0, "precision without a dot")
    `FSP_ASSERT_NOW(a_plus_space_excl, 1'b1, !(flag_reg[FL_PLUS] && flag_reg[FL_SPACE]), "plus and space both held")
    `FSP_ASSERT_NEXT(a_clear_after_emit, step_fire && emit, phase_reg == PH_FLAG && flag_reg == '0 && !pseen_reg, "state not cleared after a spec")

endmodule

// ===== verif/format_spec_parser_test.sv =====
// Self-checking testbench of the format specifier parser.
// Needs fsp_pkg and format_spec_parser. A parser built into the bench predicts every
// result, and a checker compares each accepted result with the oldest prediction.
module format_spec_parser_test;
    import fsp_pkg::*;

    localparam int          HALF_HIGH    = 6;
    localparam int          HALF_LOW     = 6;
    localparam int          RESET_CYCLES = 9;
    localparam int          TARGET_WORDS = 1600;
    localparam int          LIMIT_CYCLES = 200000;
    localparam int          SETTLE       = 16;
    localparam int unsigned DIGIT_LIMIT  = (NUMBER_BITS >= 16) ? 65535 :
                                           ((1 << NUMBER_BITS) - 1);

    typedef struct packed {
        logic [1:0]       status;
        logic [4:0]       flags;
        logic [ACC_W-1:0] width;
        logic [ACC_W-1:0] prec;
        logic             prec_on;
        logic [2:0]       len;
        logic [3:0]       conv;
    } spec_result_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             char_valid = 1'b0;
    logic             char_ready;
    logic [7:0]       char_code = 8'h00;
    logic             result_valid;
    logic             result_ready = 1'b0;
    logic [1:0]       status;
    logic [4:0]       flag_bits;
    logic [ACC_W-1:0] field_width;
    logic [ACC_W-1:0] precision_value;
    logic             precision_present;
    logic [2:0]       length_kind;
    logic [3:0]       conversion;

    // Parse state of the bench's own parser.
    phase_t           spec_phase;
    logic [4:0]       spec_flags;
    logic [ACC_W-1:0] spec_width;
    logic [ACC_W-1:0] spec_prec;
    logic             spec_prec_on;
    logic [2:0]       spec_len;

    spec_result_t pending_specs[$];
    int           mismatches = 0;
    int           words_sent = 0;
    int           burst_left = 0;
    int unsigned  rx_cycle = 0;
    int           rx_mode = 0;

    format_spec_parser DUT (
        .clk               (clk),
        .rst_n             (rst_n),
        .char_valid        (char_valid),
        .char_ready        (char_ready),
        .char_code         (char_code),
        .result_valid      (result_valid),
        .result_ready      (result_ready),
        .status            (status),
        .flag_bits         (flag_bits),
        .field_width       (field_width),
        .precision_value   (precision_value),
        .precision_present (precision_present),
        .length_kind       (length_kind),
        .conversion        (conversion)
    );

    // Clock.
    always
    begin
        #HALF_HIGH clk = 1'b1;
        #HALF_LOW clk = 1'b0;
    end

    // Returns the parser to an empty spec in the flag phase.
    function automatic void clear_spec();
        spec_phase   = PH_FLAG;
        spec_flags   = '0;
        spec_width   = '0;
        spec_prec    = '0;
        spec_prec_on = 1'b0;
        spec_len     = LEN_NONE;
    endfunction

    // Appends a decimal digit to a run, saturating at the run limit.
    function automatic logic [ACC_W-1:0] append_digit(input logic [ACC_W-1:0] acc,
                                                      input logic [7:0] c);
        int unsigned v;
        v = int'(acc) * 10 + int'(c) - int'(CH_ZERO);
        if (v > DIGIT_LIMIT)
            v = DIGIT_LIMIT;
        return ACC_W'(v);
    endfunction

    function automatic logic char_is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // Copies the parse state into a result and clears it.
    function automatic spec_result_t close_spec(input logic [1:0] st, input logic [3:0] cv);
        spec_result_t r;
        r.status  = st;
        r.flags   = spec_flags;
        r.width   = spec_width;
        r.prec    = spec_prec;
        r.prec_on = spec_prec_on;
        r.len     = spec_len;
        r.conv    = cv;
        clear_spec();
        return r;
    endfunction

    // Consumes one word; returns 1 with the finished spec when the word ends it.
    // A word that does not fit the current phase falls through to the next one.
    function automatic logic parse_spec_char(input logic [7:0] c, output spec_result_t r);
        logic       held;
        logic       fired;
        logic [3:0] cv;
        held  = 1'b1;
        fired = 1'b0;
        r     = '0;
        if (c == CH_NUL)
        begin
            if (spec_phase == PH_LEN_H)
                spec_len = LEN_H;
            else if (spec_phase == PH_LEN_L)
                spec_len = LEN_L;
            r = close_spec(ST_EARLY_END, CONV_NONE);
            return 1'b1;
        end
        while (held)
        begin
            case (spec_phase)
                PH_FLAG:
                begin
                    held = 1'b0;
                    if (c == CH_SHARP)
                        spec_flags[FL_SHARP] = 1'b1;
                    else if (c == CH_PLUS)
                    begin
                        spec_flags[FL_PLUS]  = 1'b1;
                        spec_flags[FL_SPACE] = 1'b0;
                    end
                    else if (c == CH_SPACE)
                    begin
                        if (!spec_flags[FL_PLUS])
                            spec_flags[FL_SPACE] = 1'b1;
                    end
                    else if (c == CH_MINUS)
                    begin
                        spec_flags[FL_MINUS] = 1'b1;
                        spec_flags[FL_ZERO]  = 1'b0;
                    end
                    else if (c == CH_ZERO)
                    begin
                        if (!spec_flags[FL_MINUS])
                            spec_flags[FL_ZERO] = 1'b1;
                    end
                    else
                    begin
                        held       = 1'b1;
                        spec_phase = PH_WIDTH;
                    end
                end
                PH_WIDTH:
                begin
                    if (char_is_digit(c))
                    begin
                        spec_width = append_digit(spec_width, c);
                        held       = 1'b0;
                    end
                    else if (c == CH_DOT)
                    begin
                        spec_prec_on = 1'b1;
                        spec_prec    = '0;
                        spec_phase   = PH_PREC;
                        held         = 1'b0;
                    end
                    else
                        spec_phase = PH_LEN;
                end
                PH_PREC:
                begin
                    if (char_is_digit(c))
                    begin
                        spec_prec = append_digit(spec_prec, c);
                        held      = 1'b0;
                    end
                    else
                        spec_phase = PH_LEN;
                end
                PH_LEN:
                begin
                    held = 1'b0;
                    if (c == CH_H)
                        spec_phase = PH_LEN_H;
                    else if (c == CH_L)
                        spec_phase = PH_LEN_L;
                    else if (c == CH_J)
                    begin
                        spec_len   = LEN_J;
                        spec_phase = PH_CONV;
                    end
                    else if (c == CH_Z)
                    begin
                        spec_len   = LEN_Z;
                        spec_phase = PH_CONV;
                    end
                    else
                    begin
                        held       = 1'b1;
                        spec_phase = PH_CONV;
                    end
                end
                PH_LEN_H:
                begin
                    spec_phase = PH_CONV;
                    if (c == CH_H)
                    begin
                        spec_len = LEN_HH;
                        held     = 1'b0;
                    end
                    else
                        spec_len = LEN_H;
                end
                PH_LEN_L:
                begin
                    spec_phase = PH_CONV;
                    if (c == CH_L)
                    begin
                        spec_len = LEN_LL;
                        held     = 1'b0;
                    end
                    else
                        spec_len = LEN_L;
                end
                default:
                begin
                    case (c)
                        CH_S:       cv = CONV_S;
                        CH_P:       cv = CONV_P;
                        CH_D, CH_I: cv = CONV_D;
                        CH_O:       cv = CONV_O;
                        CH_U:       cv = CONV_U;
                        CH_X:       cv = CONV_X;
                        CH_C:       cv = CONV_C;
                        default:    cv = CONV_UNKNOWN;
                    endcase
                    r     = close_spec((cv == CONV_UNKNOWN) ? ST_UNKNOWN : ST_COMPLETE, cv);
                    held  = 1'b0;
                    fired = 1'b1;
                end
            endcase
        end
        return fired;
    endfunction

    // Sends one word in bursts with random gaps, then predicts its effect once it
    // is accepted. Called and returns just after a rising edge.
    task automatic send_word(input logic [7:0] c);
        spec_result_t r;
        if (burst_left == 0)
        begin
            char_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 24);
        end
        burst_left--;
        char_valid <= 1'b1;
        char_code  <= c;
        // Ready is stable by the falling edge, so the word goes at the next rising one.
        @(negedge clk);
        while (!char_ready)
            @(negedge clk);
        @(posedge clk);
        words_sent++;
        if (parse_spec_char(c, r))
            pending_specs.push_back(r);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_word(s[i]);
    endtask

    // Holds the sender back until every predicted result has come out.
    task automatic wait_results_drained();
        char_valid <= 1'b0;
        @(posedge clk);
        while (pending_specs.size() != 0)
            @(posedge clk);
    endtask

    // Compares one field of a result and reports a difference.
    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Result checker: the handshake is sampled at the falling edge, where both sides
    // are stable up to the rising edge that takes the result.
    always @(negedge clk)
    begin
        spec_result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_specs.size() == 0)
            begin
                $display("%0t: result with no prediction waiting, status %0d conversion %0d",
                         $time, status, conversion);
                mismatches++;
            end
            else
            begin
                want = pending_specs.pop_front();
                check_field("status", 32'(want.status), 32'(status));
                check_field("flag_bits", 32'(want.flags), 32'(flag_bits));
                check_field("field_width", 32'(want.width), 32'(field_width));
                check_field("precision_value", 32'(want.prec), 32'(precision_value));
                check_field("precision_present", 32'(want.prec_on),
                            32'(precision_present));
                check_field("length_kind", 32'(want.len), 32'(length_kind));
                check_field("conversion", 32'(want.conv), 32'(conversion));
            end
        end
    end

    // Receiver: new stall mode when rx_cycle[6:0] wraps, one of them a long hold-off.
    always @(posedge clk)
    begin
        if (rx_cycle[6:0] == 7'd0)
            rx_mode = $urandom_range(0, 3);
        case (rx_mode)
            0:       result_ready <= 1'b1;
            1:       result_ready <= 1'($urandom_range(0, 1));
            2:       result_ready <= ($urandom_range(0, 4) == 0);
            default: result_ready <= (rx_cycle[6:0] >= 7'd40);
        endcase
        rx_cycle++;
    end

    // Flag priority: plus beats space, minus beats zero.
    task automatic test_flag_priority();
        send_text("+ #-0i");
    endtask

    // A width run beyond the limit saturates.
    task automatic test_width_saturation();
        send_text("70000o");
    endtask

    // Dot with no digits, a lone l before another word, ll, and a lone h before NUL.
    task automatic test_lone_modifiers();
        send_text(".lz");
        send_text("llu");
        send_word(CH_H);
        send_word(CH_NUL);
    endtask

    // Any word after a complete modifier is the conversion, here a second dot.
    task automatic test_second_modifier();
        send_text("z.");
    endtask

    // NUL straight away, then the top code as an unknown conversion.
    task automatic test_end_of_string();
        send_word(CH_NUL);
        send_word(8'hFF);
    endtask

    function automatic logic [7:0] pick_flag_char();
        case ($urandom_range(0, 4))
            0:       return CH_SHARP;
            1:       return CH_PLUS;
            2:       return CH_SPACE;
            3:       return CH_MINUS;
            default: return CH_ZERO;
        endcase
    endfunction

    function automatic logic [7:0] pick_conversion_char();
        case ($urandom_range(0, 11))
            0:       return CH_S;
            1:       return CH_P;
            2:       return CH_D;
            3:       return CH_I;
            4:       return CH_O;
            5:       return CH_U;
            6:       return CH_X;
            7:       return CH_C;
            8:       return CH_NUL;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_digits(input int count);
        for (int i = 0; i < count; i++)
            send_word(8'(CH_ZERO + 8'($urandom_range(0, 9))));
    endtask

    // One spec with random content; a broken one carries a stray word before the
    // conversion, and some end on NUL half way through.
    task automatic send_random_spec(input logic broken);
        int n;
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++)
            send_word(pick_flag_char());
        case ($urandom_range(0, 9))
            0, 1, 2, 3: ;
            9:          send_digits($urandom_range(5, 7));
            default:    send_digits($urandom_range(1, 3));
        endcase
        if ($urandom_range(0, 1))
        begin
            send_word(CH_DOT);
            send_digits(($urandom_range(0, 9) == 0) ? 6 : $urandom_range(0, 4));
        end
        if ($urandom_range(0, 15) == 0)
        begin
            send_word(CH_NUL);
            return;
        end
        case ($urandom_range(0, 6))
            1: send_word(CH_H);
            2: send_text("hh");
            3: send_word(CH_L);
            4: send_text("ll");
            5: send_word(CH_J);
            6: send_word(CH_Z);
            default: ;
        endcase
        if (broken)
        begin
            case ($urandom_range(0, 4))
                0:       send_word(CH_DOT);
                1:       send_word(CH_H);
                2:       send_word(CH_L);
                3:       send_word(CH_J);
                default: send_word(CH_Z);
            endcase
        end
        send_word(pick_conversion_char());
    endtask

    // Mostly well-formed specs, some broken ones and some raw noise, with one
    // pause half way through until the results have all come out.
    task automatic test_random_specs();
        int  pick;
        int  n;
        logic paused;
        paused = 1'b0;
        while (words_sent < TARGET_WORDS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 12)
            begin
                n = $urandom_range(1, 5);
                for (int i = 0; i < n; i++)
                    send_word(8'($urandom_range(0, 255)));
            end
            else
                send_random_spec(pick < 22);
            if (!paused && words_sent > TARGET_WORDS / 2)
            begin
                wait_results_drained();
                paused = 1'b1;
            end
        end
    endtask

    // Stimulus and end of run.
    initial
    begin
        clear_spec();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_flag_priority();
        test_width_saturation();
        test_lone_modifiers();
        test_second_modifier();
        test_end_of_string();
        wait_results_drained();
        test_random_specs();
        wait_results_drained();
        repeat (SETTLE) @(posedge clk);
        if (mismatches == 0 && pending_specs.size() == 0)
            $display("format_spec_parser verification clean");
        else
            $display("format_spec_parser verification failed");
        $finish;
    end

    // Timeout.
    initial
    begin
        #(LIMIT_CYCLES * (HALF_HIGH + HALF_LOW));
        $display("format_spec_parser verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/fsp_pkg.sv
rtl/core/format_spec_parser.sv
verif/format_spec_parser_test.sv
